// ----- hdl/lfpd_pkg.sv -----
`timescale 1ns / 1ps

package lfpd_pkg;

  // sensor array
  localparam int CHANNELS      = 8;
  localparam int PAT_W         = CHANNELS;
  localparam int SUM_W         = 5;                    // signed sum of weights, |sum| <= 10
  localparam int CNT_W         = $clog2(CHANNELS + 1); // active channel count

  // fixed point
  localparam int FRAC_BITS_DEF = 8;
  localparam int GAIN_FRAC     = 8;
  localparam int GAIN_W        = 16;
  localparam int SPEED_W       = 11;
  localparam int OUT_W         = 12;

  // deadband: |mean| < 0.6  <=>  5*|sum| < 3*cnt
  localparam int DB_SUM_MUL    = 5;
  localparam int DB_CNT_MUL    = 3;
  localparam int DB_W          = 7;

  // integral limit selection, whole units (scaled by FRAC_BITS at use)
  localparam int THR_ERR       = 3;
  localparam int LIM_HI        = 80;
  localparam int LIM_MID       = 50;
  localparam int LIM_LO        = 20;

  // configuration port
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_KP     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KI     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KD     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CRUISE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT  = 3'd4;

  localparam logic [GAIN_W-1:0]  KP_RST     = 16'd15360;
  localparam logic [GAIN_W-1:0]  KI_RST     = 16'd0;
  localparam logic [GAIN_W-1:0]  KD_RST     = 16'd5120;
  localparam logic [SPEED_W-1:0] CRUISE_RST = 11'd200;
  localparam logic [SPEED_W-1:0] LIMIT_RST  = 11'd400;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_PID,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_MUL_WAIT,
    ST_CORR,
    ST_SPEED,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic issue;  // operands valid this cycle
    logic first;  // product starts a new sum
  } mac_ctl_t;

  // weights -4..-1 left of center, +1..+4 right of center
  function automatic logic signed [SUM_W-1:0] channel_weight(input int ch);
    logic signed [SUM_W-1:0] w;
    if (ch < CHANNELS / 2) begin
      w = SUM_W'(ch - CHANNELS / 2);
    end else begin
      w = SUM_W'(ch - CHANNELS / 2 + 1);
    end
    return w;
  endfunction

endpackage

// ----- hdl/line_follow_pid_drive.sv -----
`timescale 1ns / 1ps

// Line follower PID steering with differential wheel drive.
// Input stream (s_*): one request per control tick, s_tdata[7:0] is the sensor
// pattern (bit 0 = leftmost channel, 1 = channel sees the line).
// Output stream (m_*): one result per request. m_tdata holds left_cmd [11:0]
// and right_cmd [23:12], both signed mm/s; m_tuser is still_locked.
// Config port: cfg_we/cfg_addr/cfg_wdata writes kp, ki, kd (Q8.8), cruise speed
// and speed limit; write only while no request is in flight.
// Sequencing: one request at a time; s_tready is high only in the idle state.
// A locked tick goes from the evaluate state straight to the done state. With
// the line lost or inside the deadband the divider is skipped; otherwise the
// iterative divider runs first, giving one quotient bit per cycle, ahead of the
// PID, multiply, correction and speed states. Next request is taken the cycle
// after the result is loaded.
// The output register holds the result until m_tready; a new request is
// accepted meanwhile, and a finished result waits in the done state until the
// output register is free.
// Reset (rst, synchronous): start lock set, error history and integral zero,
// registers to defaults, no result pending.
module line_follow_pid_drive #(
  parameter int FRAC_BITS = lfpd_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lfpd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lfpd_pkg::PAT_W-1:0]          s_tdata,   // [7:0] sensor_pattern
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [2*lfpd_pkg::OUT_W-1:0]        m_tdata,   // [11:0] left_cmd, [23:12] right_cmd
  output logic                                m_tuser    // [0] still_locked
);

  localparam int DIV_W   = lfpd_pkg::SUM_W - 1 + FRAC_BITS;  // |sum| << FRAC_BITS
  localparam int ERR_W   = DIV_W;                            // error, |e| <= 4.0
  localparam int DER_W   = FRAC_BITS + 5;                    // e - prev, |d| <= 8.0
  localparam int INT_W   = FRAC_BITS + 8;                    // integral, |i| <= 80.0
  localparam int ACC_W   = INT_W + lfpd_pkg::GAIN_W + 1;
  localparam int SHIFT   = lfpd_pkg::GAIN_FRAC + FRAC_BITS;
  localparam int CORR_W  = ACC_W - SHIFT;
  localparam int SPD_W   = CORR_W + 1;
  localparam int OUT_W   = lfpd_pkg::OUT_W;
  localparam int SUM_W   = lfpd_pkg::SUM_W;
  localparam int CNT_W   = lfpd_pkg::CNT_W;
  localparam int DB_W    = lfpd_pkg::DB_W;

  // ---------------- configuration registers ----------------
  logic [lfpd_pkg::GAIN_W-1:0]  kp_gain, ki_gain, kd_gain;
  logic [lfpd_pkg::SPEED_W-1:0] cruise_speed, speed_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain      <= lfpd_pkg::KP_RST;
      ki_gain      <= lfpd_pkg::KI_RST;
      kd_gain      <= lfpd_pkg::KD_RST;
      cruise_speed <= lfpd_pkg::CRUISE_RST;
      speed_limit  <= lfpd_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lfpd_pkg::CFG_KP:     kp_gain      <= cfg_wdata;
        lfpd_pkg::CFG_KI:     ki_gain      <= cfg_wdata;
        lfpd_pkg::CFG_KD:     kd_gain      <= cfg_wdata;
        lfpd_pkg::CFG_CRUISE: cruise_speed <= cfg_wdata[lfpd_pkg::SPEED_W-1:0];
        lfpd_pkg::CFG_LIMIT:  speed_limit  <= cfg_wdata[lfpd_pkg::SPEED_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------- control state ----------------
  lfpd_pkg::state_t state, state_next;

  logic                    start_lock;
  logic signed [ERR_W-1:0] prev_err;
  logic signed [INT_W-1:0] integral;

  // per-tick working registers
  logic [lfpd_pkg::PAT_W-1:0] pat;
  logic signed [ERR_W-1:0]    err;
  logic signed [DER_W-1:0]    deriv;
  logic signed [CORR_W-1:0]   corr;
  logic signed [OUT_W-1:0]    res_left, res_right;
  logic                       res_locked;

  // ---------------- sensor decode ----------------
  logic signed [SUM_W-1:0] sum, neg_sum;
  logic [CNT_W-1:0]        cnt;
  logic [SUM_W-2:0]        abs_sum;
  logic                    deadband;
  logic                    trivial;
  logic                    hold_lock;
  logic                    skip_div;

  always_comb begin
    sum = '0;
    cnt = '0;
    for (int ch = 0; ch < lfpd_pkg::CHANNELS; ch++) begin
      if (pat[ch]) begin
        sum = sum + lfpd_pkg::channel_weight(ch);
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  assign neg_sum   = -sum;
  assign abs_sum   = sum[SUM_W-1] ? neg_sum[SUM_W-2:0] : sum[SUM_W-2:0];
  // exact deadband on the rational mean
  assign deadband  = (DB_W'(abs_sum) * DB_W'(lfpd_pkg::DB_SUM_MUL))
                   < (DB_W'(cnt) * DB_W'(lfpd_pkg::DB_CNT_MUL));
  assign trivial   = (pat == '0) || (pat == '1);
  assign hold_lock = start_lock && trivial;
  assign skip_div  = (cnt == '0) || deadband;

  // ---------------- divider ----------------
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] quotient;
  logic [DIV_W-1:0] dividend;

  assign dividend = {abs_sum, {FRAC_BITS{1'b0}}};

  lfpd_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------- integral update ----------------
  logic [ERR_W-1:0]        abs_err;
  logic signed [ERR_W-1:0] neg_err;
  logic [ERR_W:0]          thr3;
  logic signed [INT_W:0]   lim;
  logic signed [INT_W:0]   int_sum;
  logic signed [INT_W-1:0] int_base;
  logic signed [INT_W-1:0] int_next;
  logic                    sign_flip;

  assign neg_err   = -err;
  assign abs_err   = err[ERR_W-1] ? neg_err : err;
  assign thr3      = (ERR_W + 1)'(lfpd_pkg::THR_ERR) << FRAC_BITS;
  assign sign_flip = ((prev_err > 0) && (err < 0)) || ((prev_err < 0) && (err > 0));
  assign int_base  = sign_flip ? '0 : integral;
  assign int_sum   = (INT_W + 1)'(int_base) + (INT_W + 1)'(err);

  always_comb begin
    if ({1'b0, abs_err} > thr3) begin
      lim = (INT_W + 1)'(lfpd_pkg::LIM_HI) << FRAC_BITS;
    end else if ({abs_err, 1'b0} > thr3) begin
      lim = (INT_W + 1)'(lfpd_pkg::LIM_MID) << FRAC_BITS;
    end else begin
      lim = (INT_W + 1)'(lfpd_pkg::LIM_LO) << FRAC_BITS;
    end
  end

  always_comb begin
    priority if (int_sum > lim) begin
      int_next = lim[INT_W-1:0];
    end else if (int_sum < -lim) begin
      int_next = INT_W'(-lim);
    end else begin
      int_next = int_sum[INT_W-1:0];
    end
  end

  // ---------------- shared multiplier ----------------
  lfpd_pkg::mac_ctl_t          mac_ctl;
  logic [lfpd_pkg::GAIN_W-1:0] mac_gain;
  logic signed [INT_W-1:0]     mac_opnd;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     acc_bias;

  lfpd_mac #(
    .OPND_W (INT_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .gain (mac_gain),
    .opnd (mac_opnd),
    .acc  (acc)
  );

  // truncate toward zero: bias negatives before the arithmetic shift
  assign acc_bias = acc + (acc[ACC_W-1] ? ((ACC_W'(1) << SHIFT) - ACC_W'(1)) : '0);

  // ---------------- speed mixing ----------------
  logic signed [SPD_W-1:0] cruise_s, limit_s;
  logic signed [SPD_W-1:0] left_raw, right_raw;

  assign cruise_s  = SPD_W'($signed({1'b0, cruise_speed}));
  assign limit_s   = SPD_W'($signed({1'b0, speed_limit}));
  assign left_raw  = cruise_s + SPD_W'(corr);
  assign right_raw = cruise_s - SPD_W'(corr);

  function automatic logic signed [OUT_W-1:0] clamp_speed(
    input logic signed [SPD_W-1:0] v,
    input logic signed [SPD_W-1:0] lmt
  );
    logic signed [SPD_W-1:0] r;
    priority if (v > lmt) begin
      r = lmt;
    end else if (v < -lmt) begin
      r = -lmt;
    end else begin
      r = v;
    end
    return r[OUT_W-1:0];
  endfunction

  // ---------------- sequencer ----------------
  logic out_free;
  logic out_load;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      lfpd_pkg::ST_IDLE:     if (s_tvalid) state_next = lfpd_pkg::ST_EVAL;
      lfpd_pkg::ST_EVAL: begin
        priority if (hold_lock) state_next = lfpd_pkg::ST_DONE;
        else if (skip_div)      state_next = lfpd_pkg::ST_PID;
        else                    state_next = lfpd_pkg::ST_DIV;
      end
      lfpd_pkg::ST_DIV:      if (div_done) state_next = lfpd_pkg::ST_PID;
      lfpd_pkg::ST_PID:      state_next = lfpd_pkg::ST_MUL_P;
      lfpd_pkg::ST_MUL_P:    state_next = lfpd_pkg::ST_MUL_I;
      lfpd_pkg::ST_MUL_I:    state_next = lfpd_pkg::ST_MUL_D;
      lfpd_pkg::ST_MUL_D:    state_next = lfpd_pkg::ST_MUL_WAIT;
      lfpd_pkg::ST_MUL_WAIT: state_next = lfpd_pkg::ST_CORR;
      lfpd_pkg::ST_CORR:     state_next = lfpd_pkg::ST_SPEED;
      lfpd_pkg::ST_SPEED:    state_next = lfpd_pkg::ST_DONE;
      lfpd_pkg::ST_DONE:     if (out_free) state_next = lfpd_pkg::ST_IDLE;
      default:               state_next = lfpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    div_start     = 1'b0;
    mac_ctl.issue = 1'b0;
    mac_ctl.first = 1'b0;
    mac_gain      = kp_gain;
    mac_opnd      = INT_W'(err);
    out_load      = 1'b0;
    unique case (state)
      lfpd_pkg::ST_IDLE:  s_tready  = 1'b1;
      lfpd_pkg::ST_EVAL:  div_start = !hold_lock && !skip_div;
      lfpd_pkg::ST_MUL_P: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.first = 1'b1;
      end
      lfpd_pkg::ST_MUL_I: begin
        mac_ctl.issue = 1'b1;
        mac_gain      = ki_gain;
        mac_opnd      = integral;
      end
      lfpd_pkg::ST_MUL_D: begin
        mac_ctl.issue = 1'b1;
        mac_gain      = kd_gain;
        mac_opnd      = INT_W'(deriv);
      end
      lfpd_pkg::ST_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lfpd_pkg::ST_IDLE;
      start_lock <= 1'b1;
      prev_err   <= '0;
      integral   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lfpd_pkg::ST_EVAL && !hold_lock) begin
        start_lock <= 1'b0;
      end
      if (state == lfpd_pkg::ST_PID) begin
        prev_err <= err;
        integral <= int_next;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pat <= s_tdata;
    end
    if (state == lfpd_pkg::ST_EVAL) begin
      res_locked <= hold_lock;
      res_left   <= '0;
      res_right  <= '0;
      if (cnt == '0) begin
        err <= prev_err;  // line lost: hold last error
      end else if (deadband) begin
        err <= '0;
      end
    end
    if (state == lfpd_pkg::ST_DIV && div_done) begin
      err <= sum[SUM_W-1] ? -$signed(quotient) : $signed(quotient);
    end
    if (state == lfpd_pkg::ST_PID) begin
      deriv <= DER_W'(err) - DER_W'(prev_err);
    end
    if (state == lfpd_pkg::ST_CORR) begin
      corr <= acc_bias[ACC_W-1:SHIFT];
    end
    if (state == lfpd_pkg::ST_SPEED) begin
      res_left  <= clamp_speed(left_raw, limit_s);
      res_right <= clamp_speed(right_raw, limit_s);
    end
    if (out_load) begin
      m_tdata <= {res_right, res_left};
      m_tuser <= res_locked;
    end
  end

endmodule

// ----- hdl/lfpd_div.sv -----
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module lfpd_div #(
  parameter int DIV_W = lfpd_pkg::SUM_W - 1 + lfpd_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [DIV_W-1:0]             dividend,
  input  logic [lfpd_pkg::CNT_W-1:0]   divisor,
  output logic                         done,
  output logic [DIV_W-1:0]             quotient
);

  localparam int CTR_W = $clog2(DIV_W + 1);
  localparam int RW    = lfpd_pkg::CNT_W;

  logic             busy;
  logic [CTR_W-1:0] cnt;
  logic [RW-1:0]    rem;
  logic [RW:0]      shifted;
  logic [RW+1:0]    diff;

  assign shifted = {rem, quotient[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CTR_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CTR_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CTR_W'(1);
        if (cnt == CTR_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (diff[RW+1]) begin
        rem      <= shifted[RW-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end else begin
        rem      <= diff[RW-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end
    end
  end

endmodule

// ----- hdl/lfpd_mac.sv -----
`timescale 1ns / 1ps

// shared gain multiplier: registered product, then accumulate
module lfpd_mac #(
  parameter int OPND_W = lfpd_pkg::FRAC_BITS_DEF + 8
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  lfpd_pkg::mac_ctl_t                            ctl,
  input  logic [lfpd_pkg::GAIN_W-1:0]                   gain,
  input  logic signed [OPND_W-1:0]                      opnd,
  output logic signed [OPND_W+lfpd_pkg::GAIN_W:0]       acc
);

  localparam int ACC_W = OPND_W + lfpd_pkg::GAIN_W + 1;

  logic signed [ACC_W-1:0] prod;
  logic                    p_vld;
  logic                    p_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld   <= 1'b0;
      p_first <= 1'b0;
    end else begin
      p_vld   <= ctl.issue;
      p_first <= ctl.first;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod <= $signed({1'b0, gain}) * opnd;
    end
    if (p_vld) begin
      acc <= p_first ? prod : acc + prod;
    end
  end

endmodule

// ----- hdl/lfpd_checker.sv -----
`timescale 1ns / 1ps

module lfpd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [2*lfpd_pkg::OUT_W-1:0]     m_tdata,
  input logic                             m_tuser
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a locked tick always carries zero speeds
  a_locked_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("locked result with nonzero speed");

  // one request in flight: not ready in the cycle after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken while busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/sv/line_follow_pid_drive_tb.sv -----
`timescale 1ns / 1ps

// Line follower PID drive testbench.
// Sensor patterns go in as requests on the s_* stream. A behavioral copy of the
// steering loop (start lock, weighted line error, deadband, integral clear and
// limit, PID, wheel clamp) predicts each wheel command. A monitor on m_* checks
// every result against the oldest prediction. Both stream sides idle at random.
module line_follow_pid_drive_tb;

  localparam int FB           = lfpd_pkg::FRAC_BITS_DEF;
  localparam int CORR_SHIFT   = lfpd_pkg::GAIN_FRAC + FB;
  localparam int PAD_W        = lfpd_pkg::CFG_DATA_W - lfpd_pkg::SPEED_W;
  localparam int SETTLE_CYC   = FB + 24;     // a bit over the slowest request latency
  localparam int RANDOM_ITEMS = 350;
  localparam int CHUNK_ITEMS  = 50;
  localparam int MAX_REPORTS  = 200;

  typedef struct packed {
    logic signed [lfpd_pkg::OUT_W-1:0] left;
    logic signed [lfpd_pkg::OUT_W-1:0] right;
    logic                              locked;
  } wheel_cmd_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [lfpd_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [lfpd_pkg::PAT_W-1:0]      s_tdata   = '0;   // [7:0] sensor_pattern
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [2*lfpd_pkg::OUT_W-1:0]    m_tdata;          // [11:0] left_cmd, [23:12] right_cmd
  logic                            m_tuser;          // [0] still_locked

  // Predicted wheel commands, oldest first.
  wheel_cmd_t wheel_cmd_q[$];

  // Shadow of the block's registers and loop state.
  logic [lfpd_pkg::GAIN_W-1:0]  kp_q     = lfpd_pkg::KP_RST;
  logic [lfpd_pkg::GAIN_W-1:0]  ki_q     = lfpd_pkg::KI_RST;
  logic [lfpd_pkg::GAIN_W-1:0]  kd_q     = lfpd_pkg::KD_RST;
  logic [lfpd_pkg::SPEED_W-1:0] cruise_q = lfpd_pkg::CRUISE_RST;
  logic [lfpd_pkg::SPEED_W-1:0] limit_q  = lfpd_pkg::LIMIT_RST;
  logic                         lock_q   = 1'b1;
  logic signed [11:0]           last_err = '0;
  logic signed [15:0]           err_sum  = '0;

  // Idle controls; tests flip these to get stretches with no gaps.
  bit tx_idle_en  = 1'b1;
  bit rx_stall_en = 1'b1;

  // Simulated line position for the track-like stimulus.
  int line_pos = 3;
  int line_w   = 2;

  int fail_cnt   = 0;
  int sent_cnt   = 0;
  int locked_cnt = 0;
  int result_cnt = 0;
  int cfg_sets   = 0;

  line_follow_pid_drive u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d predictions still open", $time, wheel_cmd_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Update shadow registers; unused indexes are dropped like in the block.
  task automatic set_model_reg(input logic [lfpd_pkg::CFG_ADDR_W-1:0] addr,
                               input logic [lfpd_pkg::CFG_DATA_W-1:0] data);
    case (addr)
      lfpd_pkg::CFG_KP:     kp_q     = data;
      lfpd_pkg::CFG_KI:     ki_q     = data;
      lfpd_pkg::CFG_KD:     kd_q     = data;
      lfpd_pkg::CFG_CRUISE: cruise_q = data[lfpd_pkg::SPEED_W-1:0];
      lfpd_pkg::CFG_LIMIT:  limit_q  = data[lfpd_pkg::SPEED_W-1:0];
      default: ;
    endcase
  endtask

  // One control tick: works out the wheel command and queues it.
  task automatic predict_tick(input logic [lfpd_pkg::PAT_W-1:0] pat);
    int         ch, wsum, nact, sabs, err, eabs, mag, lim, integ;
    longint     acc, corr, lft, rgt, lmt;
    wheel_cmd_t cmd;
    cmd = '0;
    if (lock_q && (pat == '0 || pat == '1)) begin
      // still waiting at the start: zero speeds, no state change
      cmd.locked = 1'b1;
      wheel_cmd_q.push_back(cmd);
      locked_cnt++;
      return;
    end
    lock_q = 1'b0;

    wsum = 0;
    nact = 0;
    for (ch = 0; ch < lfpd_pkg::CHANNELS; ch++) begin
      if (pat[ch]) begin
        wsum += (ch < lfpd_pkg::CHANNELS / 2) ? ch - lfpd_pkg::CHANNELS / 2
                                              : ch - lfpd_pkg::CHANNELS / 2 + 1;
        nact++;
      end
    end
    sabs = (wsum < 0) ? -wsum : wsum;

    if (nact == 0) begin
      err = last_err;                    // line lost: hold last error
    end else if (lfpd_pkg::DB_SUM_MUL * sabs < lfpd_pkg::DB_CNT_MUL * nact) begin
      err = 0;                           // |mean| < 0.6
    end else begin
      mag = (sabs << FB) / nact;
      err = (wsum < 0) ? -mag : mag;
    end

    // integral restarts when the error flips side
    if ((last_err > 0 && err < 0) || (last_err < 0 && err > 0)) err_sum = '0;

    eabs = (err < 0) ? -err : err;
    if (eabs > (lfpd_pkg::THR_ERR << FB)) begin
      lim = lfpd_pkg::LIM_HI << FB;
    end else if (2 * eabs > (lfpd_pkg::THR_ERR << FB)) begin
      lim = lfpd_pkg::LIM_MID << FB;
    end else begin
      lim = lfpd_pkg::LIM_LO << FB;
    end
    integ = err_sum + err;
    if (integ > lim) integ = lim;
    if (integ < -lim) integ = -lim;
    err_sum = 16'(integ);

    acc = longint'(kp_q) * err + longint'(ki_q) * integ
        + longint'(kd_q) * (err - last_err);
    corr = (acc < 0) ? -((-acc) >>> CORR_SHIFT) : (acc >>> CORR_SHIFT);
    last_err = 12'(err);

    lmt = longint'(limit_q);
    lft = longint'(cruise_q) + corr;
    rgt = longint'(cruise_q) - corr;
    if (lft > lmt) lft = lmt;
    if (lft < -lmt) lft = -lmt;
    if (rgt > lmt) rgt = lmt;
    if (rgt < -lmt) rgt = -lmt;
    cmd.left  = lfpd_pkg::OUT_W'(lft);
    cmd.right = lfpd_pkg::OUT_W'(rgt);
    wheel_cmd_q.push_back(cmd);
  endtask

  // Sends one sensor request. tvalid is only lowered when a gap follows, so a
  // back-to-back request never sees a low and a high in the same step.
  task automatic send_pattern(input logic [lfpd_pkg::PAT_W-1:0] pat);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tick(pat);
    sent_cnt++;
  endtask

  // Stop sending and let every open prediction come back, then settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (wheel_cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [lfpd_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [lfpd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    set_model_reg(addr, data);
  endtask

  // Full register load while the block is idle; spare upper bits and an
  // unused index are thrown in, the block must ignore both.
  task automatic load_cfg(input logic [lfpd_pkg::GAIN_W-1:0]  kp,
                          input logic [lfpd_pkg::GAIN_W-1:0]  ki,
                          input logic [lfpd_pkg::GAIN_W-1:0]  kd,
                          input logic [lfpd_pkg::SPEED_W-1:0] cruise,
                          input logic [lfpd_pkg::SPEED_W-1:0] limit);
    drain();
    write_cfg(lfpd_pkg::CFG_KP, kp);
    write_cfg(lfpd_pkg::CFG_KI, ki);
    write_cfg(lfpd_pkg::CFG_KD, kd);
    write_cfg(lfpd_pkg::CFG_CRUISE, {PAD_W'($urandom), cruise});
    write_cfg(lfpd_pkg::CFG_LIMIT, {PAD_W'($urandom), limit});
    write_cfg(lfpd_pkg::CFG_ADDR_W'(lfpd_pkg::CFG_LIMIT + $urandom_range(1, 3)),
              lfpd_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    cfg_sets++;
  endtask

  // Line under the array drifting slowly, with dropouts, crossings and noise.
  function automatic logic [lfpd_pkg::PAT_W-1:0] track_pattern();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return lfpd_pkg::PAT_W'($urandom);
    if (roll < 13) return '0;
    if (roll < 15) return '1;
    if (roll < 20) line_w = $urandom_range(1, 3);
    else if (roll < 38) line_pos += $urandom_range(0, 1) ? 1 : -1;
    if (line_pos < 0) line_pos = 0;
    if (line_pos > lfpd_pkg::CHANNELS - line_w) line_pos = lfpd_pkg::CHANNELS - line_w;
    return lfpd_pkg::PAT_W'(((1 << line_w) - 1) << line_pos);
  endfunction

  // Receiver: alternating ready runs and stalls.
  initial begin
    int run;
    forever begin
      if (!rx_stall_en || $urandom_range(0, 1)) begin
        run = $urandom_range(1, 8);
        m_tready <= 1'b1;
      end else begin
        run = pick_gap();
        if (run == 0) run = 1;
        m_tready <= 1'b0;
      end
      repeat (run) @(posedge clk);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    wheel_cmd_t                        want;
    logic signed [lfpd_pkg::OUT_W-1:0] got_l, got_r;
    if (!rst && m_tvalid && m_tready) begin
      got_l = m_tdata[lfpd_pkg::OUT_W-1:0];
      got_r = m_tdata[2*lfpd_pkg::OUT_W-1:lfpd_pkg::OUT_W];
      result_cnt++;
      if (wheel_cmd_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: result with nothing pending: left=%0d right=%0d locked=%0b",
                   $time, got_l, got_r, m_tuser);
      end else begin
        want = wheel_cmd_q.pop_front();
        if (got_l !== want.left) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: left_cmd expected %0d actual %0d", $time, want.left, got_l);
        end
        if (got_r !== want.right) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: right_cmd expected %0d actual %0d", $time, want.right, got_r);
        end
        if (m_tuser !== want.locked) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: still_locked expected %0b actual %0b",
                     $time, want.locked, m_tuser);
        end
      end
    end
  end

  // Start lock: empty and full patterns hold it, the first real pattern
  // releases it, after which empty and full are normal ticks.
  task automatic test_start_lock();
    send_pattern(8'h00);
    send_pattern(8'hFF);
    send_pattern(8'h00);
    send_pattern(8'h18);   // center pair, sums to zero -> deadband
    send_pattern(8'h00);   // line lost
    send_pattern(8'hFF);
  endtask

  // Each weight alone, limit thresholds on and at their edges, deadband edge.
  task automatic test_error_cases();
    int i;
    load_cfg(lfpd_pkg::KP_RST, 16'h0400, lfpd_pkg::KD_RST,
             lfpd_pkg::CRUISE_RST, lfpd_pkg::LIMIT_RST);
    for (i = 0; i < lfpd_pkg::CHANNELS; i++)
      send_pattern(lfpd_pkg::PAT_W'(1 << i));  // sign flip mid-way
    send_pattern(8'h03);   // mean -3.5, top limit
    send_pattern(8'h02);   // exactly -3.0, middle limit
    send_pattern(8'h0C);   // exactly -1.5, low limit
    send_pattern(8'h7C);   // 5|sum| == 3n, just outside deadband
    send_pattern(8'h28);   // mean 0.5, inside deadband
    send_pattern(8'h00);   // lost after deadband zero
    send_pattern(8'h80);
    send_pattern(8'h00);   // lost holds +4
    repeat (5) send_pattern(8'h01);
  endtask

  // Register extremes, each followed by a short drive.
  task automatic test_cfg_extremes();
    load_cfg('0, '0, '0, '0, '0);
    repeat (8) send_pattern(track_pattern());
    load_cfg('1, '1, '1, '1, '1);
    repeat (8) send_pattern(track_pattern());
    load_cfg('1, '1, '1, '0, '1);
    repeat (8) send_pattern(track_pattern());
    load_cfg('1, '0, '0, '1, '0);
    repeat (8) send_pattern(track_pattern());
    load_cfg(16'd256, 16'd64, 16'd512, 11'd1500, 11'd100);  // cruise above limit
    repeat (8) send_pattern(track_pattern());
  endtask

  // Long track runs under random settings; idling toggled per chunk.
  task automatic test_random_track();
    int n, chunk;
    bit wide;
    n = 0;
    chunk = 0;
    while (n < RANDOM_ITEMS) begin
      tx_idle_en  = (chunk % 4) != 3;
      rx_stall_en = (chunk % 3) != 2;
      wide = $urandom_range(0, 3) == 0;
      load_cfg(wide ? lfpd_pkg::GAIN_W'($urandom)
                    : lfpd_pkg::GAIN_W'($urandom_range(0, 20000)),
               wide ? lfpd_pkg::GAIN_W'($urandom)
                    : lfpd_pkg::GAIN_W'($urandom_range(0, 4096)),
               wide ? lfpd_pkg::GAIN_W'($urandom)
                    : lfpd_pkg::GAIN_W'($urandom_range(0, 12000)),
               lfpd_pkg::SPEED_W'($urandom_range(0, 2047)),
               lfpd_pkg::SPEED_W'($urandom_range(0, 2047)));
      repeat (CHUNK_ITEMS) begin
        send_pattern(track_pattern());
        n++;
        // one pause mid-stream with every result back before going on
        if (n == RANDOM_ITEMS / 2) drain();
      end
      chunk++;
    end
  endtask

  initial begin
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_start_lock();
    test_error_cases();
    test_cfg_extremes();
    test_random_track();
    drain();

    $display("Ran %0d sensor ticks (%0d under the start lock) over %0d register sets",
             sent_cnt, locked_cnt, cfg_sets);
    $display("Checked %0d wheel commands, %0d mismatches", result_cnt, fail_cnt);
    if (fail_cnt == 0 && wheel_cmd_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
